FILE: design/tfd_pkg.sv
// Shared types, codes and bit-widening helpers for the texel format decoder.
package tfd_pkg;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEXTURE_FORMAT = 1'b0,
		CFG_ALPHA_DISABLED = 1'b1
	} cfg_idx_e;

	typedef enum logic [3:0] {
		FMT_RGBA8    = 4'd0,
		FMT_RGB8     = 4'd1,
		FMT_RGBA5551 = 4'd2,
		FMT_RGB565   = 4'd3,
		FMT_RGBA4    = 4'd4,
		FMT_IA8      = 4'd5,
		FMT_RG8      = 4'd6,
		FMT_I8       = 4'd7,
		FMT_A8       = 4'd8,
		FMT_IA4      = 4'd9,
		FMT_I4       = 4'd10,
		FMT_A4       = 4'd11,
		FMT_ETC1     = 4'd12,
		FMT_ETC1A4   = 4'd13
	} fmt_e;

	typedef struct packed {
		logic [3:0] texture_format;
		logic       alpha_disabled;
	} cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	localparam logic [7:0] CHAN_MAX = 8'hFF;

	function automatic logic [7:0] w4(input logic [3:0] v);
		return {v, v};
	endfunction

	function automatic logic [7:0] w5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [7:0] w6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	// ETC1 modifier magnitudes, indexed by table and the texel's low index bit
	function automatic logic [7:0] etc_mod(input logic [2:0] tbl, input logic sel);
		logic [7:0] lo;
		logic [7:0] hi;
		unique case (tbl)
			3'd0: begin lo = 8'd2;  hi = 8'd8;   end
			3'd1: begin lo = 8'd5;  hi = 8'd17;  end
			3'd2: begin lo = 8'd9;  hi = 8'd29;  end
			3'd3: begin lo = 8'd13; hi = 8'd42;  end
			3'd4: begin lo = 8'd18; hi = 8'd60;  end
			3'd5: begin lo = 8'd24; hi = 8'd80;  end
			3'd6: begin lo = 8'd33; hi = 8'd106; end
			3'd7: begin lo = 8'd47; hi = 8'd183; end
			default: begin lo = 8'd0; hi = 8'd0; end
		endcase
		return sel ? hi : lo;
	endfunction

endpackage

FILE: design/tfd_if.sv
// Valid/ready channels carrying texel requests and decoded colors.
interface tfd_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] texel_bytes;
	logic [63:0] alpha_block;
	logic [1:0]  col_in_block;
	logic [1:0]  row_in_block;
	logic        odd_texel;

	modport source (output valid, texel_bytes, alpha_block, col_in_block, row_in_block,
		odd_texel, input ready);
	modport sink (input valid, texel_bytes, alpha_block, col_in_block, row_in_block,
		odd_texel, output ready);
endinterface

interface tfd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;

	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

FILE: design/tfd_etc1.sv
// ETC1 color decode of one texel from a 64-bit color block.
module tfd_etc1 (
	input  logic [63:0]   blk,
	input  logic [1:0]    col,
	input  logic [1:0]    row,
	output tfd_pkg::rgb_t rgb
);

	logic [3:0] texel;
	logic       second;
	logic [2:0] tbl;
	logic [7:0] mag;
	logic       neg;
	logic       diff;
	logic [7:0] base [3];
	logic [7:0] chan [3];

	localparam int unsigned SHIFT [3] = '{56, 48, 40};

	always_comb begin
		texel  = {col, row};
		second = blk[32] ? row[1] : col[1];
		tbl    = second ? blk[36:34] : blk[39:37];
		mag    = tfd_pkg::etc_mod(tbl, blk[texel]);
		neg    = blk[5'd16 + {1'b0, texel}];
		diff   = blk[33];
	end

	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic [4:0] b5;
		logic [4:0] d5;
		logic [9:0] sum;

		always_comb begin
			// differential: 5-bit base plus signed 3-bit delta, wrapping
			d5 = {{2{blk[SHIFT[c]+2]}}, blk[SHIFT[c]+2 -: 3]};
			b5 = blk[SHIFT[c]+7 -: 5] + (second ? d5 : 5'd0);
			if (diff) begin
				base[c] = tfd_pkg::w5(b5);
			end else if (second) begin
				base[c] = tfd_pkg::w4(blk[SHIFT[c]+3 -: 4]);
			end else begin
				base[c] = tfd_pkg::w4(blk[SHIFT[c]+7 -: 4]);
			end
			sum = neg ? ({2'b00, base[c]} - {2'b00, mag}) : ({2'b00, base[c]} + {2'b00, mag});
			if (sum[9]) begin
				chan[c] = 8'd0;
			end else if (sum[8]) begin
				chan[c] = tfd_pkg::CHAN_MAX;
			end else begin
				chan[c] = sum[7:0];
			end
		end
	end

	assign rgb = '{red: chan[0], green: chan[1], blue: chan[2]};

endmodule

FILE: design/tfd_fmt.sv
// Per-format channel extraction and widening to RGBA8.
module tfd_fmt (
	input  tfd_pkg::cfg_t   cfg,
	input  logic [63:0]     texel_bytes,
	input  logic [63:0]     alpha_block,
	input  logic [1:0]      col,
	input  logic [1:0]      row,
	input  logic            odd,
	input  tfd_pkg::rgb_t   etc_rgb,
	output tfd_pkg::pixel_t px
);

	logic [7:0]  b0, b1, b2, b3;
	logic [15:0] h;
	logic        da;
	logic [7:0]  nib;
	logic [7:0]  etc_a;

	always_comb begin
		b0  = texel_bytes[7:0];
		b1  = texel_bytes[15:8];
		b2  = texel_bytes[23:16];
		b3  = texel_bytes[31:24];
		h   = texel_bytes[15:0];
		da  = cfg.alpha_disabled;
		nib = tfd_pkg::w4(odd ? b0[7:4] : b0[3:0]);
		// alpha nibbles run column-major, same order as the ETC1 texel index
		etc_a = tfd_pkg::w4(alpha_block[{col, row, 2'b00} +: 4]);

		px = '0;
		unique case (cfg.texture_format)
			tfd_pkg::FMT_RGBA8: begin
				px = '{b3, b2, b1, da ? tfd_pkg::CHAN_MAX : b0};
			end
			tfd_pkg::FMT_RGB8: begin
				px = '{b2, b1, b0, tfd_pkg::CHAN_MAX};
			end
			tfd_pkg::FMT_RGBA5551: begin
				px = '{tfd_pkg::w5(h[15:11]), tfd_pkg::w5(h[10:6]), tfd_pkg::w5(h[5:1]),
					(da || h[0]) ? tfd_pkg::CHAN_MAX : 8'd0};
			end
			tfd_pkg::FMT_RGB565: begin
				px = '{tfd_pkg::w5(h[15:11]), tfd_pkg::w6(h[10:5]), tfd_pkg::w5(h[4:0]),
					tfd_pkg::CHAN_MAX};
			end
			tfd_pkg::FMT_RGBA4: begin
				px = '{tfd_pkg::w4(h[15:12]), tfd_pkg::w4(h[11:8]), tfd_pkg::w4(h[7:4]),
					da ? tfd_pkg::CHAN_MAX : tfd_pkg::w4(h[3:0])};
			end
			tfd_pkg::FMT_IA8: begin
				px = da ? {b1, b0, 8'd0, tfd_pkg::CHAN_MAX} : {b1, b1, b1, b0};
			end
			tfd_pkg::FMT_RG8: begin
				px = '{b1, b0, 8'd0, tfd_pkg::CHAN_MAX};
			end
			tfd_pkg::FMT_I8: begin
				px = '{b0, b0, b0, tfd_pkg::CHAN_MAX};
			end
			tfd_pkg::FMT_A8: begin
				px = da ? {b0, b0, b0, tfd_pkg::CHAN_MAX} : {8'd0, 8'd0, 8'd0, b0};
			end
			tfd_pkg::FMT_IA4: begin
				px = da ? {tfd_pkg::w4(b0[7:4]), tfd_pkg::w4(b0[3:0]), 8'd0, tfd_pkg::CHAN_MAX}
				        : {tfd_pkg::w4(b0[7:4]), tfd_pkg::w4(b0[7:4]), tfd_pkg::w4(b0[7:4]),
				            tfd_pkg::w4(b0[3:0])};
			end
			tfd_pkg::FMT_I4: begin
				px = '{nib, nib, nib, tfd_pkg::CHAN_MAX};
			end
			tfd_pkg::FMT_A4: begin
				px = da ? {nib, nib, nib, tfd_pkg::CHAN_MAX} : {8'd0, 8'd0, 8'd0, nib};
			end
			tfd_pkg::FMT_ETC1: begin
				px = '{etc_rgb.red, etc_rgb.green, etc_rgb.blue, tfd_pkg::CHAN_MAX};
			end
			tfd_pkg::FMT_ETC1A4: begin
				px = '{etc_rgb.red, etc_rgb.green, etc_rgb.blue,
					da ? tfd_pkg::CHAN_MAX : etc_a};
			end
			default: begin
				px = '0;
			end
		endcase
	end

endmodule

FILE: design/texel_format_decoder.sv
// Texel format decoder: raw texel bytes or ETC1 block to one RGBA8 color.
//
// Takes one texel request per clock and returns its RGBA8 color from the
// result register when the output is not stalled. Requests pass through an
// input register, one pass of format decode (including the full ETC1 base,
// modifier and clamp path), and a result register; while a finished color
// waits on the output, the input register can still take one request, after
// which the input stalls. Sustained rate is one texel per clock while the
// output is not stalled. Format and alpha mode come from the write port and
// should only change while no request is in flight.
module texel_format_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tfd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	tfd_in_if.sink                           texel,
	tfd_out_if.source                        color
);

	tfd_pkg::cfg_t   cfg_q;
	logic            valid_s1;
	logic [63:0]     tb_s1;
	logic [63:0]     ab_s1;
	logic [1:0]      col_s1;
	logic [1:0]      row_s1;
	logic            odd_s1;
	logic            valid_s2;
	tfd_pkg::pixel_t px_s2;
	tfd_pkg::rgb_t   etc_rgb;
	tfd_pkg::pixel_t px;
	logic            s2_free;
	logic            s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tfd_pkg::CFG_TEXTURE_FORMAT: cfg_q.texture_format <= cfg_wdata[3:0];
				tfd_pkg::CFG_ALPHA_DISABLED: cfg_q.alpha_disabled <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign s2_free     = !valid_s2 || color.ready;
	assign s1_adv      = valid_s1 && s2_free;
	assign texel.ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (texel.ready) begin
			valid_s1 <= texel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (texel.valid && texel.ready) begin
			tb_s1  <= texel.texel_bytes;
			ab_s1  <= texel.alpha_block;
			col_s1 <= texel.col_in_block;
			row_s1 <= texel.row_in_block;
			odd_s1 <= texel.odd_texel;
		end
	end

	tfd_etc1 u_etc1 (
		.blk (tb_s1),
		.col (col_s1),
		.row (row_s1),
		.rgb (etc_rgb)
	);

	tfd_fmt u_fmt (
		.cfg         (cfg_q),
		.texel_bytes (tb_s1),
		.alpha_block (ab_s1),
		.col         (col_s1),
		.row         (row_s1),
		.odd         (odd_s1),
		.etc_rgb     (etc_rgb),
		.px          (px)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			px_s2 <= px;
		end
	end

	assign color.valid = valid_s2;
	assign color.red   = px_s2.red;
	assign color.green = px_s2.green;
	assign color.blue  = px_s2.blue;
	assign color.alpha = px_s2.alpha;

endmodule

FILE: design/tfd_checker.sv
// Port-level checks for the texel format decoder, bound to the top level.
module tfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_px
);

	// a stalled color must not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_px))
		else $error("output changed while stalled");

	// an empty output register never blocks the input
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// an accepted request shows up on the output when the output drains
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready |=> out_valid)
		else $error("accepted request did not reach the output");

	// a new color appears only for a request accepted through the input register
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("color without a request");

endmodule

bind texel_format_decoder tfd_checker u_tfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (texel.valid),
	.in_ready  (texel.ready),
	.out_valid (color.valid),
	.out_ready (color.ready),
	.out_px    ({color.red, color.green, color.blue, color.alpha})
);
